[rtl/dec_pkg.sv]
// dec_pkg: word types, button codes and calendar helpers for the date editor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dec_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 12;

  localparam logic [1:0] CMD_UP     = 2'd0;
  localparam logic [1:0] CMD_DOWN   = 2'd1;
  localparam logic [1:0] CMD_SELECT = 2'd2;
  localparam logic [1:0] CMD_BACK   = 2'd3;

  localparam logic [1:0] FLD_DAY_TENS = 2'd0;
  localparam logic [1:0] FLD_DAY_ONES = 2'd1;
  localparam logic [1:0] FLD_MONTH    = 2'd2;
  localparam logic [1:0] FLD_YEAR     = 2'd3;

  localparam logic [MonthW-1:0] MonthFirst = 4'd1;
  localparam logic [MonthW-1:0] MonthLast  = 4'd12;
  localparam logic [YearW-1:0]  YearMax    = 12'd4095;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [DayW-1:0]   cur_day;
    logic [MonthW-1:0] cur_month;
    logic [YearW-1:0]  cur_year;
  } dec_in_t;

  typedef struct packed {
    logic              editing;
    logic [1:0]        field_sel;
    logic [DayW-1:0]   edit_day;
    logic [MonthW-1:0] edit_month;
    logic [YearW-1:0]  edit_year;
    logic              commit;
    logic              leave_menu;
  } dec_out_t;

  // month length, february has 29 days when year % 4 == 0
  // out of range months count as 31 days
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] month,
                                                  input logic [YearW-1:0] year);
    logic [DayW-1:0] len;
    case (month)
      4'd2:    len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // remainder by ten of a day value
  function automatic logic [DayW-1:0] day_mod10(input logic [DayW-1:0] day);
    logic [DayW-1:0] r;
    if (day < 5'd10) begin
      r = day;
    end else if (day < 5'd20) begin
      r = day - 5'd10;
    end else if (day < 5'd30) begin
      r = day - 5'd20;
    end else begin
      r = day - 5'd30;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/date_edit_controller.sv]
// date_edit_controller: button driven date editor, one button word in, one status word out
// depends on dec_pkg
// an accepted button word is held in the input register, then its status word is registered in the output register
// throughput: one word per cycle while the output is not stalled; the edit state updates in the cycle the word
//   leaves the input register, so a word may follow in the next cycle
// reset: asynchronous, active low; idle mode, field 0, edit day, month and year 0,
//   input and output registers empty
`timescale 1ns / 1ps
`default_nettype none

module date_edit_controller import dec_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire dec_in_t  in_word_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output dec_out_t      out_word_o
);

  logic              in_valid_q;
  dec_in_t           in_q;
  logic              out_valid_q;
  dec_out_t          out_q;

  logic              edit_q, edit_d;
  logic [1:0]        field_q, field_d;
  logic [DayW-1:0]   day_q, day_d;
  logic [MonthW-1:0] month_q, month_d;
  logic [YearW-1:0]  year_q, year_d;
  logic              commit_d;

  logic              exec;
  logic              in_take;
  logic [DayW-1:0]   max_day;
  logic [DayW:0]     day_up10;
  logic [DayW:0]     day_up1;

  assign exec       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !exec;
  assign in_take    = in_valid_i && !in_stall_o;

  assign max_day  = month_days(month_q, year_q);
  assign day_up10 = {1'b0, day_q} + 6'd10;
  assign day_up1  = {1'b0, day_q} + 6'd1;

  always_comb begin
    edit_d   = edit_q;
    field_d  = field_q;
    day_d    = day_q;
    month_d  = month_q;
    year_d   = year_q;
    commit_d = 1'b0;
    if (!edit_q) begin
      if (in_q.cmd == CMD_SELECT) begin
        edit_d  = 1'b1;
        field_d = FLD_DAY_TENS;
        day_d   = in_q.cur_day;
        month_d = in_q.cur_month;
        year_d  = in_q.cur_year;
      end
    end else begin
      case (in_q.cmd)
        CMD_UP: begin
          case (field_q)
            FLD_DAY_TENS: begin
              // overflow keeps only the ones digit, which can give day 0
              day_d = (day_up10 > {1'b0, max_day}) ? day_mod10(day_q) : day_up10[DayW-1:0];
            end
            FLD_DAY_ONES: begin
              day_d = (day_up1 > {1'b0, max_day}) ? 5'd1 : day_up1[DayW-1:0];
            end
            FLD_MONTH: begin
              month_d = (month_q >= MonthLast) ? MonthFirst : month_q + 4'd1;
            end
            default: begin
              if (year_q < YearMax) year_d = year_q + 12'd1;
            end
          endcase
        end
        CMD_DOWN: begin
          case (field_q)
            FLD_DAY_TENS: day_d   = (day_q <= 5'd10) ? max_day : day_q - 5'd10;
            FLD_DAY_ONES: day_d   = (day_q <= 5'd1) ? max_day : day_q - 5'd1;
            FLD_MONTH:    month_d = (month_q <= MonthFirst) ? MonthLast : month_q - 4'd1;
            default: begin
              if (year_q != '0) year_d = year_q - 12'd1;
            end
          endcase
        end
        CMD_SELECT: begin
          field_d = field_q + 2'd1;
          if (field_q == FLD_YEAR) begin
            edit_d   = 1'b0;
            commit_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      edit_q      <= 1'b0;
      field_q     <= FLD_DAY_TENS;
      day_q       <= '0;
      month_q     <= '0;
      year_q      <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (exec) begin
        in_valid_q <= 1'b0;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
        edit_q      <= edit_d;
        field_q     <= field_d;
        day_q       <= day_d;
        month_q     <= month_d;
        year_q      <= year_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_word_i;
    end
    if (exec) begin
      out_q.editing    <= edit_d;
      out_q.field_sel  <= field_d;
      out_q.edit_day   <= day_d;
      out_q.edit_month <= month_d;
      out_q.edit_year  <= year_d;
      out_q.commit     <= commit_d;
      out_q.leave_menu <= (in_q.cmd == CMD_BACK);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_idle_field_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !edit_q |-> field_q == FLD_DAY_TENS)
    else $error("field index not zero while idle");

  a_enter_on_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(edit_q) |-> $past(exec && in_q.cmd == CMD_SELECT))
    else $error("edit mode entered without a select word");

  a_commit_leaves_edit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.commit |-> !out_q.editing && out_q.field_sel == FLD_DAY_TENS)
    else $error("commit word still shows edit mode");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec |=> $stable({edit_q, field_q, day_q, month_q, year_q}))
    else $error("edit state changed without a word");

endmodule

`default_nettype wire
